// ===== rtl/kps_pkg.sv =====
// shared widths, codes and key entry type for the keyframe position sampler
package kps_pkg;

   // field widths
   localparam int POS_W     = 32;
   localparam int TICK_W    = 24;
   localparam int MODE_W    = 2;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 2;

   // parameter defaults
   localparam int DEF_MAX_KEYS  = 64;
   localparam int DEF_FRAC_BITS = 16;

   // request modes
   localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd2;

   // response status codes
   localparam logic [STATUS_W-1:0] STAT_SAMPLED = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_REST    = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd3;

   // csr register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_REST_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REST_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REST_Z = 2'd2;

   // one stored keyframe
   typedef struct packed {
      logic [TICK_W-1:0] tick;
      logic [POS_W-1:0]  x;
      logic [POS_W-1:0]  y;
      logic [POS_W-1:0]  z;
   } key_type;

   localparam int KEY_W = $bits(key_type);

endpackage

// ===== rtl/keyframe_position_sampler_unit.sv =====
// Keyframe position sampler. Keys (tick, x, y, z) are appended to a track held
// in one synchronous ram; a word can append a key, clear the track, or sample
// it at a query tick with linear interpolation in Q16.16. Append, clear and the
// unused mode go straight from idle to the finish state, as does a sample of an
// empty track; a sample outside the key range passes through the fetch and check
// states first. An interpolated sample then scans on from key one to the first key
// past the query: the scan reads one key per cycle through the single ram read port,
// and the fraction divider retires one quotient bit per cycle, followed by one shared
// multiplier for the three axes. A new word is taken while the previous response
// still waits in the output register. The csr port is always ready.
module keyframe_position_sampler_unit #(
   parameter int MAX_KEYS  = kps_pkg::DEF_MAX_KEYS,
   parameter int FRAC_BITS = kps_pkg::DEF_FRAC_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [kps_pkg::MODE_W-1:0]   req_mode,
   input  logic [kps_pkg::TICK_W-1:0]   req_tick,
   input  logic [kps_pkg::POS_W-1:0]    req_key_x,
   input  logic [kps_pkg::POS_W-1:0]    req_key_y,
   input  logic [kps_pkg::POS_W-1:0]    req_key_z,
   // response channel
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [kps_pkg::POS_W-1:0]    rsp_pos_x,
   output logic [kps_pkg::POS_W-1:0]    rsp_pos_y,
   output logic [kps_pkg::POS_W-1:0]    rsp_pos_z,
   output logic [kps_pkg::STATUS_W-1:0] rsp_status,
   // csr write channel
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [kps_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [kps_pkg::POS_W-1:0]    csr_wdata
);
   import kps_pkg::*;

   localparam int AW    = $clog2(MAX_KEYS);
   localparam int CNT_W = $clog2(MAX_KEYS + 1);

   typedef enum logic [6:0] {
      ST_IDLE       = 7'b0000001,
      ST_FETCH_LAST = 7'b0000010,
      ST_CHECK      = 7'b0000100,
      ST_SCAN       = 7'b0001000,
      ST_DIV        = 7'b0010000,
      ST_LERP       = 7'b0100000,
      ST_FINISH     = 7'b1000000
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [AW-1:0]        idx_ff, idx_in;
   logic [TICK_W-1:0]    query_ff, query_in;
   key_type              first_ff, first_in;
   key_type              prev_ff, prev_in;
   key_type              next_ff, next_in;
   logic [POS_W-1:0]     res_x_ff, res_x_in;
   logic [POS_W-1:0]     res_y_ff, res_y_in;
   logic [POS_W-1:0]     res_z_ff, res_z_in;
   logic [STATUS_W-1:0]  res_st_ff, res_st_in;
   logic [POS_W-1:0]     rest_x_ff, rest_y_ff, rest_z_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]     rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic [STATUS_W-1:0]  rsp_st_ff;

   logic                 req_acc;
   logic                 rsp_load;
   logic [CNT_W-1:0]     last_cnt;
   logic                 ram_we;
   logic [AW-1:0]        ram_raddr;
   logic [KEY_W-1:0]     ram_rdata;
   key_type              wr_key;
   key_type              rd_key;
   logic                 div_start;
   logic                 div_done;
   logic [TICK_W-1:0]    div_num;
   logic [TICK_W-1:0]    div_den;
   logic [FRAC_BITS-1:0] frac;
   logic                 lerp_start;
   logic                 lerp_done;
   logic [POS_W-1:0]     lerp_x, lerp_y, lerp_z;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign last_cnt  = count_ff - CNT_W'(1);
   assign rd_key    = key_type'(ram_rdata);
   assign wr_key    = '{tick: req_tick, x: req_key_x, y: req_key_y, z: req_key_z};
   assign ram_we    = req_acc && (req_mode == MODE_APPEND) &&
                      (count_ff < CNT_W'(MAX_KEYS));

   // ram read address follows the state
   always_comb begin
      case (state_ff)
         ST_IDLE:       ram_raddr = '0;
         ST_FETCH_LAST: ram_raddr = last_cnt[AW-1:0];
         ST_CHECK:      ram_raddr = AW'(1);
         ST_SCAN:       ram_raddr = idx_ff + AW'(1);
         default:       ram_raddr = '0;
      endcase
   end

   // divider operands, taken when the scan finds the later key
   assign div_num = query_ff - prev_ff.tick;
   assign div_den = rd_key.tick - prev_ff.tick;

   // main sequencer
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      query_in   = query_ff;
      first_in   = first_ff;
      prev_in    = prev_ff;
      next_in    = next_ff;
      res_x_in   = res_x_ff;
      res_y_in   = res_y_ff;
      res_z_in   = res_z_ff;
      res_st_in  = res_st_ff;
      div_start  = 1'b0;
      lerp_start = 1'b0;
      rsp_load   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               res_x_in  = '0;
               res_y_in  = '0;
               res_z_in  = '0;
               res_st_in = STAT_DONE;
               query_in  = req_tick;
               state_in  = ST_FINISH;
               case (req_mode)
                  MODE_APPEND: begin
                     if (ram_we) begin
                        count_in = count_ff + CNT_W'(1);
                     end else begin
                        res_st_in = STAT_FULL;
                     end
                  end
                  MODE_CLEAR: begin
                     count_in = '0;
                  end
                  MODE_SAMPLE: begin
                     if (count_ff == '0) begin
                        res_x_in  = rest_x_ff;
                        res_y_in  = rest_y_ff;
                        res_z_in  = rest_z_ff;
                        res_st_in = STAT_REST;
                     end else begin
                        state_in = ST_FETCH_LAST;
                     end
                  end
                  default: begin
                     res_st_in = STAT_DONE;
                  end
               endcase
            end
         end
         // first key arrives
         ST_FETCH_LAST: begin
            first_in = rd_key;
            state_in = ST_CHECK;
         end
         // last key arrives, clamp or start the scan at key one
         ST_CHECK: begin
            res_st_in = STAT_SAMPLED;
            if (query_ff <= first_ff.tick) begin
               res_x_in = first_ff.x;
               res_y_in = first_ff.y;
               res_z_in = first_ff.z;
               state_in = ST_FINISH;
            end else if (query_ff >= rd_key.tick) begin
               res_x_in = rd_key.x;
               res_y_in = rd_key.y;
               res_z_in = rd_key.z;
               state_in = ST_FINISH;
            end else begin
               prev_in  = first_ff;
               idx_in   = AW'(1);
               state_in = ST_SCAN;
            end
         end
         // one key per cycle until its tick passes the query
         ST_SCAN: begin
            if (rd_key.tick > query_ff) begin
               next_in   = rd_key;
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else begin
               prev_in = rd_key;
               idx_in  = idx_ff + AW'(1);
            end
         end
         ST_DIV: begin
            if (div_done) begin
               lerp_start = 1'b1;
               state_in   = ST_LERP;
            end
         end
         ST_LERP: begin
            if (lerp_done) begin
               res_x_in  = lerp_x;
               res_y_in  = lerp_y;
               res_z_in  = lerp_z;
               res_st_in = STAT_SAMPLED;
               state_in  = ST_FINISH;
            end
         end
         // hand the word to the output register once it is free
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // rest position registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rest_x_ff <= '0;
         rest_y_ff <= '0;
         rest_z_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_REST_X: rest_x_ff <= csr_wdata;
            CSR_REST_Y: rest_y_ff <= csr_wdata;
            CSR_REST_Z: rest_z_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // working payload
   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      query_ff  <= query_in;
      first_ff  <= first_in;
      prev_ff   <= prev_in;
      next_ff   <= next_in;
      res_x_ff  <= res_x_in;
      res_y_ff  <= res_y_in;
      res_z_ff  <= res_z_in;
      res_st_ff <= res_st_in;
   end

   // output payload
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_x_ff  <= res_x_ff;
         rsp_y_ff  <= res_y_ff;
         rsp_z_ff  <= res_z_ff;
         rsp_st_ff <= res_st_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_pos_x  = rsp_x_ff;
   assign rsp_pos_y  = rsp_y_ff;
   assign rsp_pos_z  = rsp_z_ff;
   assign rsp_status = rsp_st_ff;

   // key track storage
   kps_ram #(
      .WIDTH (KEY_W),
      .DEPTH (MAX_KEYS)
   ) u_track_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_key),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // interpolation fraction
   kps_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (frac)
   );

   // per-axis interpolation
   kps_lerp #(
      .FRAC_BITS (FRAC_BITS)
   ) u_lerp (
      .clock    (clock),
      .reset    (reset),
      .start    (lerp_start),
      .frac     (frac),
      .prev_key (prev_ff),
      .next_key (next_ff),
      .done     (lerp_done),
      .pos_x    (lerp_x),
      .pos_y    (lerp_y),
      .pos_z    (lerp_z)
   );

endmodule

// ===== rtl/kps_ram.sv =====
// generic simple dual-port ram with one write port and a registered read port
module kps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/kps_div.sv =====
// restoring divider giving the interpolation fraction one bit per cycle
module kps_div #(
   parameter int FRAC_BITS = kps_pkg::DEF_FRAC_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [kps_pkg::TICK_W-1:0] num,
   input  logic [kps_pkg::TICK_W-1:0] den,
   output logic                      done,
   output logic [FRAC_BITS-1:0]      quot
);
   import kps_pkg::*;

   localparam int CW = $clog2(FRAC_BITS + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [TICK_W-1:0]   rem_ff, rem_in;
   logic [TICK_W-1:0]   den_ff, den_in;
   logic [FRAC_BITS-1:0] quot_ff, quot_in;
   logic [TICK_W:0]     rem_dbl;
   logic [TICK_W:0]     rem_sub;
   logic                fits;

   // one trial subtract per cycle, remainder stays below the divisor
   always_comb begin
      rem_dbl = {rem_ff, 1'b0};
      rem_sub = rem_dbl - {1'b0, den_ff};
      fits    = (rem_dbl >= {1'b0, den_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(FRAC_BITS);
         rem_in  = num;
         den_in  = den;
      end else if (busy_ff) begin
         rem_in  = fits ? rem_sub[TICK_W-1:0] : rem_dbl[TICK_W-1:0];
         quot_in = {quot_ff[FRAC_BITS-2:0], fits};
         cnt_in  = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

// ===== rtl/kps_lerp.sv =====
// shared multiply-add unit, steps x, y and z from the earlier key toward the later
module kps_lerp #(
   parameter int FRAC_BITS = kps_pkg::DEF_FRAC_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [FRAC_BITS-1:0]      frac,
   input  kps_pkg::key_type          prev_key,
   input  kps_pkg::key_type          next_key,
   output logic                      done,
   output logic [kps_pkg::POS_W-1:0] pos_x,
   output logic [kps_pkg::POS_W-1:0] pos_y,
   output logic [kps_pkg::POS_W-1:0] pos_z
);
   import kps_pkg::*;

   localparam int PW = POS_W + FRAC_BITS + 2;

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic                    add_ph_ff, add_ph_in;
   logic [1:0]              axis_ff, axis_in;
   logic [FRAC_BITS-1:0]    frac_ff;
   logic signed [POS_W-1:0] p_ff [3];
   logic signed [POS_W-1:0] n_ff [3];
   logic [POS_W-1:0]        res_ff [3];
   logic signed [PW-1:0]    prod_ff;
   logic signed [POS_W:0]   diff;
   logic signed [FRAC_BITS:0] frac_s;
   logic signed [PW-1:0]    prod_in;
   logic signed [PW-1:0]    step;
   logic [POS_W-1:0]        sum;

   // difference times fraction, then floor shift and add
   always_comb begin
      diff    = {n_ff[0][POS_W-1], n_ff[0]} - {p_ff[0][POS_W-1], p_ff[0]};
      frac_s  = {1'b0, frac_ff};
      prod_in = diff * frac_s;
      step    = prod_ff >>> FRAC_BITS;
      sum     = p_ff[0] + step[POS_W-1:0];
   end

   // sequencing: multiply phase then add phase per axis
   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      add_ph_in = add_ph_ff;
      axis_in   = axis_ff;
      if (start) begin
         busy_in   = 1'b1;
         add_ph_in = 1'b0;
         axis_in   = 2'd0;
      end else if (busy_ff) begin
         add_ph_in = !add_ph_ff;
         if (add_ph_ff) begin
            axis_in = axis_ff + 2'd1;
            if (axis_ff == 2'd2) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         done_ff   <= 1'b0;
         add_ph_ff <= 1'b0;
         axis_ff   <= 2'd0;
      end else begin
         busy_ff   <= busy_in;
         done_ff   <= done_in;
         add_ph_ff <= add_ph_in;
         axis_ff   <= axis_in;
      end
   end

   // operand rotation and result shift
   always_ff @(posedge clock) begin
      if (start) begin
         frac_ff <= frac;
         p_ff[0] <= prev_key.x;
         p_ff[1] <= prev_key.y;
         p_ff[2] <= prev_key.z;
         n_ff[0] <= next_key.x;
         n_ff[1] <= next_key.y;
         n_ff[2] <= next_key.z;
      end else if (busy_ff) begin
         if (!add_ph_ff) begin
            prod_ff <= prod_in;
         end else begin
            p_ff[0]   <= p_ff[1];
            p_ff[1]   <= p_ff[2];
            n_ff[0]   <= n_ff[1];
            n_ff[1]   <= n_ff[2];
            res_ff[0] <= res_ff[1];
            res_ff[1] <= res_ff[2];
            res_ff[2] <= sum;
         end
      end
   end

   assign done  = done_ff;
   assign pos_x = res_ff[0];
   assign pos_y = res_ff[1];
   assign pos_z = res_ff[2];

endmodule
